### src/tafwd_pkg.sv
// Shared types and constants of the two-table address forwarder.
package tafwd_pkg;

   localparam int ADDR_W = 32;
   localparam int PORT_W = 3;
   localparam int KIND_W = 2;
   localparam int ACTION_W = 2;

   localparam int DEFAULT_TABLE_ENTRIES = 16;

   // Input kinds; the fourth code means nothing and is ignored.
   localparam logic [KIND_W-1:0] KIND_CLIENT_REG = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FUNCTION_REG = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;

   // Result actions.
   localparam logic [ACTION_W-1:0] ACT_FORWARD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ACK = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DROP = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] source_address;
      logic [ADDR_W-1:0] destination_address;
      logic [PORT_W-1:0] arrival_port;
      logic probe_flag;
   } req_payload_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PORT_W-1:0] out_port;
      logic [ADDR_W-1:0] out_source;
      logic [ADDR_W-1:0] out_destination;
      logic out_probe;
      logic last;
   } rsp_payload_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic [ADDR_W-1:0] key;
      logic [PORT_W-1:0] port;
      logic learn_client;
      logic learn_function;
      logic fill_client;
      logic fill_function;
   } cell_cmd_type;

   // Scan record handed from cell to cell.
   typedef struct packed {
      logic active;
      logic client_hit;
      logic [PORT_W-1:0] client_port;
      logic function_hit;
      logic [PORT_W-1:0] function_port;
      logic free_found;
   } scan_type;

endpackage

### src/tafwd_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
interface tafwd_chan_if #(
   parameter type payload_type = logic
) ();
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/tafwd_cell.sv
// One table cell: a client entry, a function entry and one stage of the scan chain.
module tafwd_cell #(
   parameter int TABLE_ENTRIES = tafwd_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int CELL_INDEX = 0,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic clock,
   input  logic reset,
   input  tafwd_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0] fill_idx,
   input  tafwd_pkg::scan_type scan_in,
   input  logic [IDX_W-1:0] free_idx_in,
   output tafwd_pkg::scan_type scan_out,
   output logic [IDX_W-1:0] free_idx_out
);
   import tafwd_pkg::*;

   logic client_valid_ff;
   logic [ADDR_W-1:0] client_addr_ff;
   logic [PORT_W-1:0] client_port_ff;
   logic function_valid_ff;
   logic [ADDR_W-1:0] function_addr_ff;
   logic [PORT_W-1:0] function_port_ff;
   scan_type scan_ff;
   scan_type scan_in_next;
   logic [IDX_W-1:0] free_idx_ff;
   logic [IDX_W-1:0] free_idx_in_next;

   logic client_match;
   logic function_match;
   logic free_here;
   logic client_write;
   logic function_write;
   logic fill_here;

   // Local compare against the broadcast key.
   assign client_match = client_valid_ff && (client_addr_ff == cmd.key);
   assign function_match = function_valid_ff && (function_addr_ff == cmd.key);
   assign free_here = (cmd.learn_client && !client_valid_ff)
      || (cmd.learn_function && !function_valid_ff);
   assign fill_here = (fill_idx == IDX_W'(CELL_INDEX));

   // An existing entry is overwritten as the scan passes; a free entry is filled at scan end.
   assign client_write = (scan_in.active && cmd.learn_client && client_match)
      || (cmd.fill_client && fill_here);
   assign function_write = (scan_in.active && cmd.learn_function && function_match)
      || (cmd.fill_function && fill_here);

   // Fold this cell's result into the record; later hits, earlier free slots win.
   always_comb begin
      scan_in_next = scan_in;
      scan_in_next.client_hit = scan_in.client_hit || client_match;
      scan_in_next.client_port = client_match ? client_port_ff : scan_in.client_port;
      scan_in_next.function_hit = scan_in.function_hit || function_match;
      scan_in_next.function_port = function_match ? function_port_ff
                                                  : scan_in.function_port;
      scan_in_next.free_found = scan_in.free_found || free_here;
      free_idx_in_next = scan_in.free_found ? free_idx_in : IDX_W'(CELL_INDEX);
   end

   // Valid bits and the scan stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         client_valid_ff <= 1'b0;
         function_valid_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in_next;
         if (client_write) begin
            client_valid_ff <= 1'b1;
         end
         if (function_write) begin
            function_valid_ff <= 1'b1;
         end
      end
   end

   // Entry contents and the free index need no reset.
   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in_next;
      if (client_write) begin
         client_addr_ff <= cmd.key;
         client_port_ff <= cmd.port;
      end
      if (function_write) begin
         function_addr_ff <= cmd.key;
         function_port_ff <= cmd.port;
      end
   end

   assign scan_out = scan_ff;
   assign free_idx_out = free_idx_ff;

endmodule

### src/tafwd_ctrl.sv
// Controller: holds the item, launches the scan and issues the results.
module tafwd_ctrl #(
   parameter int TABLE_ENTRIES = tafwd_pkg::DEFAULT_TABLE_ENTRIES,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic clock,
   input  logic reset,
   tafwd_chan_if.sink req_chan,
   tafwd_chan_if.source rsp_chan,
   output tafwd_pkg::cell_cmd_type cmd,
   output logic [IDX_W-1:0] fill_idx,
   output tafwd_pkg::scan_type scan_head,
   input  tafwd_pkg::scan_type scan_tail,
   input  logic [IDX_W-1:0] tail_free_idx
);
   import tafwd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEND
   } state_type;

   state_type state_ff;
   req_payload_type item_ff;
   rsp_payload_type rsp_ff;
   logic rsp_valid_ff;
   logic ack_pending_ff;
   logic start_ff;

   logic scan_done;
   logic is_client_reg;
   logic is_function_reg;
   logic is_data;
   logic hit;
   logic [PORT_W-1:0] hit_port;
   rsp_payload_type first_rsp;
   rsp_payload_type ack_rsp;

   assign is_client_reg = (item_ff.kind == KIND_CLIENT_REG);
   assign is_function_reg = (item_ff.kind == KIND_FUNCTION_REG);
   assign is_data = (item_ff.kind == KIND_DATA);
   assign scan_done = (state_ff == ST_SCAN) && scan_tail.active;

   // Broadcast command; a fill takes the lowest free entry when that table had no match.
   always_comb begin
      cmd.key = is_data ? item_ff.destination_address : item_ff.source_address;
      cmd.port = item_ff.arrival_port;
      cmd.learn_client = is_client_reg;
      cmd.learn_function = is_function_reg;
      cmd.fill_client = scan_done && is_client_reg
         && !scan_tail.client_hit && scan_tail.free_found;
      cmd.fill_function = scan_done && is_function_reg
         && !scan_tail.function_hit && scan_tail.free_found;
   end
   assign fill_idx = tail_free_idx;

   // The record entering the first cell.
   always_comb begin
      scan_head = '0;
      scan_head.active = start_ff;
   end

   // Lookup outcome: the client table takes priority.
   assign hit = scan_tail.client_hit || scan_tail.function_hit;
   assign hit_port = scan_tail.client_hit ? scan_tail.client_port : scan_tail.function_port;

   always_comb begin
      first_rsp.action = hit ? ACT_FORWARD : ACT_DROP;
      first_rsp.out_port = hit ? hit_port : '0;
      first_rsp.out_source = item_ff.source_address;
      first_rsp.out_destination = item_ff.destination_address;
      first_rsp.out_probe = item_ff.probe_flag;
      first_rsp.last = !(hit && item_ff.probe_flag);

      ack_rsp.action = ACT_ACK;
      ack_rsp.out_port = item_ff.arrival_port;
      ack_rsp.out_source = item_ff.destination_address;
      ack_rsp.out_destination = item_ff.source_address;
      ack_rsp.out_probe = 1'b0;
      ack_rsp.last = 1'b1;
   end

   // Sequencer with the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ack_pending_ff <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         start_ff <= (state_ff == ST_IDLE) && req_chan.valid;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  item_ff <= req_chan.payload;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_tail.active) begin
                  if (is_data) begin
                     rsp_ff <= first_rsp;
                     rsp_valid_ff <= 1'b1;
                     ack_pending_ff <= hit && item_ff.probe_flag;
                     state_ff <= ST_SEND;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_SEND: begin
               if (rsp_chan.ready) begin
                  if (ack_pending_ff) begin
                     rsp_ff <= ack_rsp;
                     ack_pending_ff <= 1'b0;
                  end else begin
                     rsp_valid_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

### src/two_table_address_forwarder.sv
// Top level of the two-table address forwarder: controller and the row of table cells.
//
//   Channel    Direction  Payload
//   req_chan   in         kind, source/destination address, arrival port, probe flag
//   rsp_chan   out        action, out port, out source/destination, out probe, last
//
// One item at a time. After a transfer in, a scan record walks the row of cells one
// cell per cycle, registered in each cell; the controller registers the outcome when it
// leaves the last cell. A data packet yields a result, followed by an acknowledgement
// when it hit with the probe flag set.
// Reset clears the valid bits of both tables at once; there is no clearing pass.
// A stalled result holds the output register, and no new item is taken until it goes.
module two_table_address_forwarder #(
   parameter int TABLE_ENTRIES = tafwd_pkg::DEFAULT_TABLE_ENTRIES
) (
   input logic clock,
   input logic reset,
   tafwd_chan_if.sink req_chan,
   tafwd_chan_if.source rsp_chan
);
   import tafwd_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   cell_cmd_type cmd;
   logic [IDX_W-1:0] fill_idx;
   scan_type scan_chain [TABLE_ENTRIES+1];
   logic [IDX_W-1:0] idx_chain [TABLE_ENTRIES+1];

   assign idx_chain[0] = '0;

   tafwd_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .cmd(cmd),
      .fill_idx(fill_idx),
      .scan_head(scan_chain[0]),
      .scan_tail(scan_chain[TABLE_ENTRIES]),
      .tail_free_idx(idx_chain[TABLE_ENTRIES])
   );

   // Row of cells, each handing the scan record to the next.
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      tafwd_cell #(
         .TABLE_ENTRIES(TABLE_ENTRIES),
         .CELL_INDEX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .fill_idx(fill_idx),
         .scan_in(scan_chain[i]),
         .free_idx_in(idx_chain[i]),
         .scan_out(scan_chain[i+1]),
         .free_idx_out(idx_chain[i+1])
      );
   end

endmodule
